// ===== rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants of the scalar Kalman filter: fixed-point widths,
// reset values of the noise registers, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int CHANNELS  = 16;
    localparam int CHAN_W    = 4;
    localparam int CHAN_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FRAC_BITS = 30;
    localparam int DATA_W    = 32;
    localparam int Q30_W     = 31;
    localparam int DIV_STEPS = 30;
    localparam int CNT_W     = 5;

    localparam logic [CHAN_W:0]  CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS);
    localparam logic [Q30_W-1:0] ONE_Q30    = 31'd1073741824;
    localparam logic [Q30_W-1:0] R_RESET    = 31'd10737418;
    localparam logic [Q30_W-1:0] Q_RESET    = 31'd107374182;
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(DIV_STEPS - 1);

    typedef enum logic {
        REG_MEAS_NOISE = 1'b0,
        REG_PROC_NOISE = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PREP,
        ST_DIV,
        ST_MUL_K,
        ST_UPD_X,
        ST_MUL_P,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/scalar_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// Sixteen-channel one-dimensional Kalman filter with a shared restoring
// divider and a single shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Each input transaction carries a channel and a Q16.16 measurement and yields
// exactly one output transaction with the new estimate and the Q1.30 gain.
// An item passes these steps from acceptance until its result is offered: the
// load and prep states fetch the channel state and form the prior variance and
// divisor, the bit-serial divider produces the gain one bit per cycle, and the
// one 31 x 33 bit multiplier first forms the estimate correction and then the
// new variance. The block takes one item at a time and raises o_stall while an
// item is in flight; a finished result sits in an output register, so the
// input side opens again as soon as that register is free. Noise registers
// are clamped on write to keep the divisor non-zero, and should only be
// written while the block is idle.
module scalar_kalman_filter
    import skf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [CHAN_W-1:0]        i_channel,
    input  logic signed [DATA_W-1:0] i_measurement,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [CHAN_W-1:0]        o_channel_out,
    output logic signed [DATA_W-1:0] o_estimate_out,
    output logic [Q30_W-1:0]         o_gain_out,
    // configuration
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [Q30_W-1:0]         i_cfg_data
);

    t_state r_state, n_state;

    logic [Q30_W-1:0] r_meas_noise;
    logic [Q30_W-1:0] r_proc_noise;

    logic [DATA_W-1:0] r_est_store [CHANNELS];
    logic [DATA_W-1:0] r_var_store [CHANNELS];

    logic [CHAN_W-1:0]        r_chan;
    logic signed [DATA_W-1:0] r_meas;
    logic                     r_skip;
    logic signed [DATA_W-1:0] r_x;
    logic [DATA_W-1:0]        r_prior;
    logic [DATA_W:0]          r_div;
    logic [DATA_W:0]          r_rem;
    logic [FRAC_BITS-1:0]     r_quo;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [DATA_W:0]   r_diff;
    logic signed [64:0]       r_prod;

    logic                     r_o_valid;
    logic [CHAN_W-1:0]        r_o_chan;
    logic signed [DATA_W-1:0] r_o_est;
    logic [Q30_W-1:0]         r_o_gain;

    logic [CHAN_AW-1:0] st_idx;
    logic               out_free;
    logic               finish;
    logic               chan_bad;
    logic [DATA_W+1:0]  rem_shift;
    logic               rem_ge;
    logic [Q30_W-1:0]   mul_a;
    logic signed [DATA_W:0] mul_b;
    logic signed [64:0] mul_full;

    assign st_idx   = r_chan[CHAN_AW-1:0];
    assign chan_bad = ({1'b0, i_channel} >= CHAN_LIMIT);
    assign out_free = !r_o_valid || !i_stall;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = chan_bad ? ST_DONE : ST_LOAD;
            ST_LOAD:  n_state = ST_PREP;
            ST_PREP:  n_state = ST_DIV;
            ST_DIV:   if (r_cnt == DIV_LAST) n_state = ST_MUL_K;
            ST_MUL_K: n_state = ST_UPD_X;
            ST_UPD_X: n_state = ST_MUL_P;
            ST_MUL_P: n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        finish  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
            end
            ST_DONE: finish = out_free;
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_noise <= R_RESET;
            r_proc_noise <= Q_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_MEAS_NOISE: begin
                    if (i_cfg_data == '0) begin
                        r_meas_noise <= Q30_W'(1);
                    end else if (i_cfg_data > ONE_Q30) begin
                        r_meas_noise <= ONE_Q30;
                    end else begin
                        r_meas_noise <= i_cfg_data;
                    end
                end
                REG_PROC_NOISE: begin
                    r_proc_noise <= (i_cfg_data > ONE_Q30) ? ONE_Q30 : i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    // ---------------- shared arithmetic ----------------
    // Restoring division: the remainder stays below the divisor, so one
    // shifted compare and subtract per cycle yields one gain bit.
    assign rem_shift = {r_rem, 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, r_div});

    always_comb begin
        if (r_state == ST_MUL_P) begin
            mul_a = ONE_Q30 - {1'b0, r_quo};
            mul_b = $signed({1'b0, r_prior});
        end else begin
            mul_a = {1'b0, r_quo};
            mul_b = r_diff;
        end
    end

    assign mul_full = $signed({1'b0, mul_a}) * mul_b;

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_chan <= i_channel;
                r_meas <= i_measurement;
                r_skip <= chan_bad;
                r_quo  <= '0;
            end
            ST_LOAD: begin
                r_x     <= r_est_store[st_idx];
                r_prior <= r_var_store[st_idx] + DATA_W'(r_proc_noise);
            end
            ST_PREP: begin
                r_div  <= {1'b0, r_prior} + (DATA_W + 1)'(r_meas_noise);
                r_rem  <= {1'b0, r_prior};
                r_diff <= (DATA_W + 1)'(r_meas) - (DATA_W + 1)'(r_x);
                r_cnt  <= '0;
            end
            ST_DIV: begin
                if (rem_ge) begin
                    r_rem <= (DATA_W + 1)'(rem_shift - {1'b0, r_div});
                end else begin
                    r_rem <= rem_shift[DATA_W:0];
                end
                r_quo <= {r_quo[FRAC_BITS-2:0], rem_ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ST_MUL_K: r_prod <= mul_full;
            // Low word of the floored shift gives the wrapped new estimate.
            ST_UPD_X: r_x <= r_x + r_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
            ST_MUL_P: r_prod <= mul_full;
            default: ;
        endcase
    end

    // ---------------- channel state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_est_store[i] <= '0;
                r_var_store[i] <= DATA_W'(ONE_Q30);
            end
        end else if (finish && !r_skip) begin
            r_est_store[st_idx] <= r_x;
            r_var_store[st_idx] <= r_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (finish) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_o_chan <= r_chan;
            r_o_est  <= r_skip ? '0 : r_x;
            r_o_gain <= r_skip ? '0 : {1'b0, r_quo};
        end
    end

    assign o_valid        = r_o_valid;
    assign o_channel_out  = r_o_chan;
    assign o_estimate_out = r_o_est;
    assign o_gain_out     = r_o_gain;

endmodule
